// File: design/bpc_pkg.sv
// Shared types, constants and helpers for the barometric pressure compensation block.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  localparam int unsigned DivWidth = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned TempSideW  = 58;
  localparam int unsigned PressSideW = 18;

  localparam logic [CfgIdxW-1:0] CFG_CAL_A1  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAL_A2  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CAL_B   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CAL_M   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OSR     = 3'd4;

  localparam logic signed [31:0] B6Offset   = 32'sd4000;
  localparam logic signed [31:0] B4Offset   = 32'sd32768;
  localparam logic [31:0]        PressScale = 32'd50000;
  localparam logic signed [31:0] PressC1    = 32'sd3038;
  localparam logic signed [31:0] PressC2    = -32'sd7357;
  localparam logic signed [31:0] PressC3    = 32'sd3791;
  localparam logic signed [31:0] PressMax   = 32'sd1048575;
  localparam logic signed [31:0] TempMax    = 32'sd32767;
  localparam logic signed [31:0] TempMin    = -32'sd32768;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         osr;
  } cal_t;

  typedef struct packed {
    logic [23:0]        up;
    logic signed [31:0] b6;
    logic signed [15:0] t;
    logic               fault;
  } mid_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic [19:0]        p;
    logic               fault;
  } res_t;

  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a,
                                                  input int unsigned k);
    logic signed [31:0] bias;
    bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (a + bias) >>> k;
  endfunction

endpackage
`default_nettype wire

// File: design/bpc_if.sv
// Handshake channel interfaces for raw readings and compensated results.
`timescale 1ns / 1ps
`default_nettype none
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic [19:0]        pressure_pa;
  logic               divide_fault;
  modport source (output valid, temperature_tenths, pressure_pa, divide_fault, input ready);
  modport sink (input valid, temperature_tenths, pressure_pa, divide_fault, output ready);
endinterface
`default_nettype wire

// File: design/bpc_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module bpc_div #(
  parameter int unsigned Width = bpc_pkg::DivWidth,
  parameter int unsigned SideW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [Width-1:0] num_i,
  input  wire logic [Width-1:0] den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output logic [Width-1:0]      quo_o,
  output logic [SideW-1:0]      side_o
);

  logic             vld_q  [Width];
  logic [Width-1:0] rem_q  [Width];
  logic [Width-1:0] num_q  [Width];
  logic [Width-1:0] den_q  [Width];
  logic [SideW-1:0] side_q [Width];

  for (genvar i = 0; i < Width; i++) begin : g_stage
    logic             v_in;
    logic [Width-1:0] rem_in, num_in, den_in;
    logic [SideW-1:0] side_in;
    logic [Width:0]   shf, dif;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign num_in  = num_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign shf = {rem_in, num_in[Width-1]};
    assign dif = shf - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= dif[Width] ? shf[Width-1:0] : dif[Width-1:0];
        num_q[i]  <= {num_in[Width-2:0], ~dif[Width]};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Width-1];
  assign quo_o   = num_q[Width-1];
  assign side_o  = side_q[Width-1];

endmodule
`default_nettype wire

// File: design/bpc_temp.sv
// Temperature path: X1, pipelined X2 division, B5, temperature and B6.
`timescale 1ns / 1ps
`default_nettype none
module bpc_temp (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire bpc_pkg::cal_t cal_i,
  input  wire logic         valid_i,
  input  wire logic [15:0]  ut_i,
  input  wire logic [23:0]  up_raw_i,
  output logic              valid_o,
  output bpc_pkg::mid_t     mid_o
);

  logic               v0_q;
  logic signed [31:0] prod0_q;
  logic [23:0]        up0_q;
  logic signed [31:0] diff0;

  assign diff0 = $signed({16'd0, ut_i}) - $signed({16'd0, cal_i.ac6});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod0_q <= diff0 * $signed({16'd0, cal_i.ac5});
      up0_q   <= 24'(up_raw_i >> (4'd8 - {2'b00, cal_i.osr}));
    end
  end

  logic signed [31:0] x1, den, num;
  logic               neg, zero;
  logic [31:0]        num_abs, den_abs;

  assign x1      = bpc_pkg::sdiv_p2(prod0_q, 15);
  assign den     = x1 + 32'(cal_i.md);
  assign num     = {{5{cal_i.mc[15]}}, cal_i.mc, 11'd0};
  assign neg     = num[31] ^ den[31];
  assign zero    = (den == 32'sd0);
  assign num_abs = num[31] ? 32'(-num) : 32'(num);
  assign den_abs = den[31] ? 32'(-den) : 32'(den);

  logic                                  dv;
  logic [31:0]                           quo;
  logic [bpc_pkg::TempSideW-1:0]         side;

  bpc_div #(
    .Width (bpc_pkg::DivWidth),
    .SideW (bpc_pkg::TempSideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v0_q),
    .num_i   (num_abs),
    .den_i   (den_abs),
    .side_i  ({x1, up0_q, neg, zero}),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (side)
  );

  logic signed [31:0] x1_d, x2, b5, tw;
  logic [23:0]        up_d;
  logic signed [15:0] t16;

  assign x1_d = side[57:26];
  assign up_d = side[25:2];
  assign x2   = side[1] ? -$signed(quo) : $signed(quo);
  assign b5   = x1_d + x2;
  assign tw   = bpc_pkg::sdiv_p2(b5 + 32'sd8, 4);

  always_comb begin
    if (tw > bpc_pkg::TempMax) begin
      t16 = 16'sh7fff;
    end else if (tw < bpc_pkg::TempMin) begin
      t16 = 16'sh8000;
    end else begin
      t16 = tw[15:0];
    end
  end

  logic          v2_q;
  bpc_pkg::mid_t mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q.up    <= up_d;
      mid_q.b6    <= b5 - bpc_pkg::B6Offset;
      mid_q.t     <= t16;
      mid_q.fault <= side[0];
    end
  end

  assign valid_o = v2_q;
  assign mid_o   = mid_q;

endmodule
`default_nettype wire

// File: design/bpc_press.sv
// Pressure path: B3, B4, B7, pipelined pressure division, correction and saturation.
`timescale 1ns / 1ps
`default_nettype none
module bpc_press (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire bpc_pkg::cal_t cal_i,
  input  wire logic          valid_i,
  input  wire bpc_pkg::mid_t mid_i,
  output logic               valid_o,
  output bpc_pkg::res_t      res_o
);

  logic v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v10_q, v11_q, v12_q;

  logic signed [31:0] sqp3_q, pa2_3_q, pa3_3_q;
  bpc_pkg::mid_t      m3_q, m4_q, m5_q, m6_q;
  logic signed [31:0] sq4_q, x2a4_q, x1c4_q;
  logic signed [31:0] pb2_5_q, pb1_5_q, x2a5_q, x1c5_q;
  logic signed [31:0] b3_6_q, s6_q;
  logic [31:0]        b4p7_q, diff7_q;
  logic [15:0]        t7_q, t8_q;
  logic               f7_q, f8_q;
  logic [16:0]        b4_8_q;
  logic [31:0]        b7_8_q;
  logic signed [31:0] p10_q, x1p10_q, x2p10_q;
  logic signed [31:0] p11_q, m11_q, x2_11_q;
  logic [15:0]        t10_q, t11_q;
  logic               f10_q, f11_q;
  bpc_pkg::res_t      res_q;

  logic                           dv;
  logic [31:0]                    quo;
  logic [bpc_pkg::PressSideW-1:0] side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else if (en_i) begin
      v3_q  <= valid_i;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v10_q <= dv;
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  logic signed [31:0] x1_6, x3_6, t0_6, x2_6, x3b_6;
  logic [31:0]        b3sh_6;

  assign x1_6   = bpc_pkg::sdiv_p2(pb2_5_q, 11);
  assign x3_6   = x1_6 + x2a5_q;
  assign b3sh_6 = 32'(cal_i.ac1 * 32'sd4 + x3_6) << cal_i.osr;
  assign t0_6   = $signed(b3sh_6) + 32'sd2;
  assign x2_6   = bpc_pkg::sdiv_p2(pb1_5_q, 16);
  assign x3b_6  = bpc_pkg::sdiv_p2(x1c5_q + x2_6 + 32'sd2, 2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqp3_q  <= mid_i.b6 * mid_i.b6;
      pa2_3_q <= 32'(cal_i.ac2) * mid_i.b6;
      pa3_3_q <= 32'(cal_i.ac3) * mid_i.b6;
      m3_q    <= mid_i;

      sq4_q  <= bpc_pkg::sdiv_p2(sqp3_q, 12);
      x2a4_q <= bpc_pkg::sdiv_p2(pa2_3_q, 11);
      x1c4_q <= bpc_pkg::sdiv_p2(pa3_3_q, 13);
      m4_q   <= m3_q;

      pb2_5_q <= 32'(cal_i.b2) * sq4_q;
      pb1_5_q <= 32'(cal_i.b1) * sq4_q;
      x2a5_q  <= x2a4_q;
      x1c5_q  <= x1c4_q;
      m5_q    <= m4_q;

      b3_6_q <= bpc_pkg::sdiv_p2(t0_6, 2);
      s6_q   <= x3b_6 + bpc_pkg::B4Offset;
      m6_q   <= m5_q;

      b4p7_q  <= {16'd0, cal_i.ac4} * $unsigned(s6_q);
      diff7_q <= {8'd0, m6_q.up} - $unsigned(b3_6_q);
      t7_q    <= m6_q.t;
      f7_q    <= m6_q.fault;

      b4_8_q <= b4p7_q[31:15];
      b7_8_q <= diff7_q * (bpc_pkg::PressScale >> cal_i.osr);
      t8_q   <= t7_q;
      f8_q   <= f7_q;
    end
  end

  logic        dbl9, f9;
  logic [31:0] dvd9;

  assign dbl9 = ~b7_8_q[31];
  assign dvd9 = dbl9 ? {b7_8_q[30:0], 1'b0} : b7_8_q;
  assign f9   = f8_q | (b4_8_q == 17'd0);

  bpc_div #(
    .Width (bpc_pkg::DivWidth),
    .SideW (bpc_pkg::PressSideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v8_q),
    .num_i   (dvd9),
    .den_i   ({15'd0, b4_8_q}),
    .side_i  ({t8_q, f9, dbl9}),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (side)
  );

  logic signed [31:0] p10, d10, x1_12, p12;

  assign p10   = side[0] ? $signed(quo) : $signed({quo[30:0], 1'b0});
  assign d10   = bpc_pkg::sdiv_p2(p10, 8);
  assign x1_12 = bpc_pkg::sdiv_p2(m11_q, 16);
  assign p12   = p11_q + bpc_pkg::sdiv_p2(x1_12 + x2_11_q + bpc_pkg::PressC3, 4);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p10_q   <= p10;
      x1p10_q <= d10 * d10;
      x2p10_q <= bpc_pkg::PressC2 * p10;
      t10_q   <= side[17:2];
      f10_q   <= side[1];

      p11_q   <= p10_q;
      m11_q   <= x1p10_q * bpc_pkg::PressC1;
      x2_11_q <= bpc_pkg::sdiv_p2(x2p10_q, 16);
      t11_q   <= t10_q;
      f11_q   <= f10_q;

      res_q.fault <= f11_q;
      if (f11_q) begin
        res_q.t <= '0;
        res_q.p <= '0;
      end else begin
        res_q.t <= t11_q;
        if (p12 < 32'sd0) begin
          res_q.p <= '0;
        end else if (p12 > bpc_pkg::PressMax) begin
          res_q.p <= 20'hfffff;
        end else begin
          res_q.p <= p12[19:0];
        end
      end
    end
  end

  assign valid_o = v12_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

// File: design/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation pipeline.
//
// Usage: calibration words and the oversampling mode are written through the
// plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) while the block is idle.
// Raw readings enter on in_ch (raw temperature and 24-bit raw pressure), one
// item per cycle when in_ch.ready is high. Each item gives one result on
// out_ch: temperature in tenths of a degree, pressure in pascals and a
// divide fault flag that zeroes both values.
// The path from in_ch to out_ch.valid has 75 register stages. Throughput is one
// item per cycle while out_ch accepts, set by two 32-stage restoring dividers
// (one quotient bit per stage) and short multiply stages between them.
// Reset clears all valid bits and the calibration registers to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready drops; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module barometric_pressure_compensation (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bpc_pkg::CfgDataW-1:0] cfg_data_i,
  bpc_in_if.sink                            in_ch,
  bpc_out_if.source                         out_ch
);

  logic [47:0] cal_a1_q, cal_a2_q;
  logic [31:0] cal_b_q, cal_m_q;
  logic [1:0]  osr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a1_q <= '0;
      cal_a2_q <= '0;
      cal_b_q  <= '0;
      cal_m_q  <= '0;
      osr_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpc_pkg::CFG_CAL_A1: cal_a1_q <= cfg_data_i;
        bpc_pkg::CFG_CAL_A2: cal_a2_q <= cfg_data_i;
        bpc_pkg::CFG_CAL_B:  cal_b_q  <= cfg_data_i[31:0];
        bpc_pkg::CFG_CAL_M:  cal_m_q  <= cfg_data_i[31:0];
        bpc_pkg::CFG_OSR:    osr_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  bpc_pkg::cal_t cal;

  assign cal.ac1 = cal_a1_q[47:32];
  assign cal.ac2 = cal_a1_q[31:16];
  assign cal.ac3 = cal_a1_q[15:0];
  assign cal.ac4 = cal_a2_q[47:32];
  assign cal.ac5 = cal_a2_q[31:16];
  assign cal.ac6 = cal_a2_q[15:0];
  assign cal.b1  = cal_b_q[31:16];
  assign cal.b2  = cal_b_q[15:0];
  assign cal.mc  = cal_m_q[31:16];
  assign cal.md  = cal_m_q[15:0];
  assign cal.osr = osr_q;

  logic          en, mid_valid, res_valid;
  bpc_pkg::mid_t mid;
  bpc_pkg::res_t res;

  assign en          = ~res_valid | out_ch.ready;
  assign in_ch.ready = en;

  bpc_temp u_temp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cal_i    (cal),
    .valid_i  (in_ch.valid),
    .ut_i     (in_ch.raw_temperature),
    .up_raw_i (in_ch.raw_pressure),
    .valid_o  (mid_valid),
    .mid_o    (mid)
  );

  bpc_press u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cal_i   (cal),
    .valid_i (mid_valid),
    .mid_i   (mid),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign out_ch.valid              = res_valid;
  assign out_ch.temperature_tenths = res.t;
  assign out_ch.pressure_pa        = res.p;
  assign out_ch.divide_fault       = res.fault;

endmodule
`default_nettype wire
